// ===== hw/rtl/sample_ring_queue_with_burst_drain_defines.svh =====
// Assertion macros shared by the sample ring queue RTL.
`ifndef SAMPLE_RING_QUEUE_WITH_BURST_DRAIN_DEFINES_SVH
`define SAMPLE_RING_QUEUE_WITH_BURST_DRAIN_DEFINES_SVH

// Clocked assertion that is switched off while reset is held.
`define SRQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds while reset is held.
`define SRQ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/srq_pkg.sv =====
// Package with sizes, codes and the fill-level function of the sample ring queue.
`timescale 1ns / 1ps

package srq_pkg;

  localparam int QUEUE_DEPTH = 4096;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int MAX_BURST   = 64;
  localparam int BURST_W     = 7;
  localparam int BYTE_W      = 8;
  localparam int SAMPLE_W    = 16;

  localparam logic [PTR_W-1:0]   FULL_CNT  = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [PTR_W-1:0]   NEAR_TH   = PTR_W'(QUEUE_DEPTH - 4);
  localparam logic [PTR_W-1:0]   HALF_TH   = PTR_W'(QUEUE_DEPTH / 2);
  localparam logic [BURST_W-1:0] BURST_MAX = BURST_W'(MAX_BURST);

  localparam logic CMD_STORE = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  typedef enum logic [1:0] {
    LVL_HALF  = 2'd0,
    LVL_RIGHT = 2'd1,
    LVL_NEAR  = 2'd2
  } level_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_POP  = 3'b010,
    ST_SIL  = 3'b100
  } state_t;

  function automatic level_t level_of(input logic [PTR_W-1:0] cnt);
    level_t lv;
    if (cnt >= NEAR_TH) begin
      lv = LVL_NEAR;
    end else if (cnt <= HALF_TH) begin
      lv = LVL_HALF;
    end else begin
      lv = LVL_RIGHT;
    end
    return lv;
  endfunction

endpackage

// ===== hw/rtl/srq_ram.sv =====
// Simple dual-port RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module srq_ram #(
  parameter int DATA_W = 8,
  parameter int ADDR_W = 12
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  localparam int DEPTH = 1 << ADDR_W;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/sample_ring_queue_with_burst_drain.sv =====
// Top level of the sample ring queue: byte store, fill status and burst drain.
//
// Channel  Dir  tdata (low bit up)                        tuser / tlast
// in_      in   sample_byte[7:0], drain_samples[14:8]     tuser: cmd
// out_     out  sample[15:0], level[17:16], fill[29:18]   tuser: dropped, underrun; tlast
//
// A store gives one word. A drain of N samples with 2N or more bytes stored is accepted,
// starts the RAM read, then gives one word per cycle while the output is not stalled;
// with fewer it gives N zero words flagged underrun. A drain of zero samples gives nothing.
// Input words are taken only while no drain is running and the output register is free.
// Reset clears the pointers and control; the byte store needs no clearing.
// A stalled output holds the RAM read, so the drain resumes without loss.
`timescale 1ns / 1ps
`include "sample_ring_queue_with_burst_drain_defines.svh"

module sample_ring_queue_with_burst_drain
  import srq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // sample_byte[7:0], drain_samples[14:8], zero
  input  logic        in_tuser,   // cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // sample[15:0], level[17:16], fill_count[29:18], zero
  output logic        out_tlast,
  output logic [1:0]  out_tuser   // dropped, underrun
);

  state_t              state_r, state_nxt;
  logic [PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [BURST_W-1:0]  rem_r, rem_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [SAMPLE_W-1:0] sample_r, sample_nxt;
  logic                last_r, last_nxt;
  level_t              level_r, level_nxt;
  logic [PTR_W-1:0]    fill_r, fill_nxt;
  logic                drop_r, drop_nxt;
  logic                und_r, und_nxt;

  logic                in_fire;
  logic                can_load;
  logic                cmd;
  logic [BYTE_W-1:0]   in_byte;
  logic [BURST_W-1:0]  n_req;
  logic [BURST_W-1:0]  n_sat;
  logic [BURST_W:0]    twice_n;
  logic [PTR_W-1:0]    count;
  logic [PTR_W-1:0]    count_inc;
  logic                full;
  logic                ram_we;
  logic                ram_re;
  logic [BYTE_W-1:0]   ram_rdata;

  assign cmd       = in_tuser;
  assign in_byte   = in_tdata[7:0];
  assign n_req     = in_tdata[14:8];
  assign n_sat     = (n_req > BURST_MAX) ? BURST_MAX : n_req;
  assign twice_n   = {n_sat, 1'b0};
  assign count     = wr_ptr_r - rd_ptr_r;
  assign count_inc = count + PTR_W'(1);
  assign full      = (count == FULL_CNT);
  assign can_load  = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE) && can_load;
  assign in_fire   = in_tvalid && in_tready;

  srq_ram #(
    .DATA_W(BYTE_W),
    .ADDR_W(PTR_W)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wr_ptr_r),
    .wdata(in_byte),
    .re   (ram_re),
    .raddr(rd_ptr_r),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    wr_ptr_nxt    = wr_ptr_r;
    rd_ptr_nxt    = rd_ptr_r;
    rem_nxt       = rem_r;
    out_valid_nxt = out_valid_r;
    sample_nxt    = sample_r;
    last_nxt      = last_r;
    level_nxt     = level_r;
    fill_nxt      = fill_r;
    drop_nxt      = drop_r;
    und_nxt       = und_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (cmd == CMD_STORE) begin
            out_valid_nxt = 1'b1;
            sample_nxt    = '0;
            last_nxt      = 1'b1;
            drop_nxt      = full;
            und_nxt       = 1'b0;
            if (full) begin
              level_nxt = level_of(count);
              fill_nxt  = count;
            end else begin
              ram_we     = 1'b1;
              wr_ptr_nxt = wr_ptr_r + PTR_W'(1);
              level_nxt  = level_of(count_inc);
              fill_nxt   = count_inc;
            end
          end else if (n_sat != '0) begin
            rem_nxt = n_sat;
            if (count < PTR_W'(twice_n)) begin
              state_nxt = ST_SIL;
            end else begin
              ram_re     = 1'b1;
              rd_ptr_nxt = rd_ptr_r + PTR_W'(1);
              state_nxt  = ST_POP;
            end
          end
        end
      end
      ST_POP: begin
        if (can_load) begin
          out_valid_nxt = 1'b1;
          sample_nxt    = {ram_rdata, 8'h00};
          last_nxt      = (rem_r == BURST_W'(1));
          level_nxt     = level_of(count);
          fill_nxt      = count;
          drop_nxt      = 1'b0;
          und_nxt       = 1'b0;
          rem_nxt       = rem_r - BURST_W'(1);
          if (rem_r == BURST_W'(1)) begin
            state_nxt = ST_IDLE;
          end else begin
            ram_re     = 1'b1;
            rd_ptr_nxt = rd_ptr_r + PTR_W'(1);
          end
        end
      end
      ST_SIL: begin
        if (can_load) begin
          out_valid_nxt = 1'b1;
          sample_nxt    = '0;
          last_nxt      = (rem_r == BURST_W'(1));
          level_nxt     = level_of(count);
          fill_nxt      = count;
          drop_nxt      = 1'b0;
          und_nxt       = 1'b1;
          rem_nxt       = rem_r - BURST_W'(1);
          if (rem_r == BURST_W'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sample_r <= sample_nxt;
    last_r   <= last_nxt;
    level_r  <= level_nxt;
    fill_r   <= fill_nxt;
    drop_r   <= drop_nxt;
    und_r    <= und_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, fill_r, level_r, sample_r};
  assign out_tlast  = last_r;
  assign out_tuser  = {und_r, drop_r};

  `SRQ_ASSERT(a_pop_hold, (state_r == ST_POP && !can_load) |=> $stable(ram_rdata), "Read moved")
  `SRQ_ASSERT(a_last_idle, (out_valid_r && last_r) |-> (state_r == ST_IDLE), "Last mid-drain")
  `SRQ_ASSERT(a_busy_rem, (state_r != ST_IDLE) |-> (rem_r != '0), "Drain has no samples left")
  `SRQ_ASSERT(a_pop_keeps_wr, (state_r == ST_POP) |=> $stable(wr_ptr_r), "Store in a drain")

endmodule
